[hw/rtl/tso_pkg.sv]
// shared types and codes for the two-stack block
`default_nettype none

package tso_pkg;

  localparam logic [1:0] ACT_PUSH = 2'd0;
  localparam logic [1:0] ACT_POP  = 2'd1;
  localparam logic [1:0] ACT_DISP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [6:0] CAP_RESET = 7'd64;

  typedef struct packed {
    logic [1:0]         action;
    logic               which_stack;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic disp;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       empty;
    logic       disp_last;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/tso_ctrl.sv]
// control state machine: accept, execute, display sweep
`default_nettype none

module tso_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  tso_pkg::dp_stat_t  stat_i,
  output tso_pkg::ctl_cmd_t  cmd_o
);
  import tso_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DISP = 2'd2;

  logic [1:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.action == ACT_DISP && !stat_i.empty) state_d = S_DISP;
        else state_d = S_IDLE;
      end
      S_DISP: begin
        if (stat_i.disp_last) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy       = (state_q != S_IDLE);
  assign cmd_o.load = start && (state_q == S_IDLE);
  assign cmd_o.exec = (state_q == S_EXEC);
  assign cmd_o.disp = (state_q == S_DISP);

endmodule

`default_nettype wire

[hw/rtl/tso_dp.sv]
// datapath: shared entry memory, stack counts, capacity and result registers
`default_nettype none

module tso_dp #(
  parameter int DEPTH = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  tso_pkg::ctl_cmd_t  cmd_i,
  input  tso_pkg::in_item_t  item_i,
  input  wire                cap_we_i,
  input  wire  [6:0]         cap_wdata_i,
  output logic [6:0]         cap_o,
  output tso_pkg::dp_stat_t  stat_o,
  output logic               res_valid_o,
  output tso_pkg::out_item_t res_o
);
  import tso_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;

  in_item_t      item_q;
  logic [6:0]    cap_q;
  logic [CW-1:0] low_q, low_d, high_q, high_d;
  logic [AW-1:0] idx_q, idx_d;

  logic          vld_q, vld_d;
  logic [1:0]    st_q, st_d;
  logic          last_q, last_d;
  logic          fmem_q, fmem_d;

  logic [CW-1:0] cap_w, cnt_sel, idx_w;
  logic          empty, ovf, disp_last;
  logic          we, re;
  logic [CW-1:0] addr_w;

  assign cap_w     = (cap_q > 7'(DEPTH)) ? CW'(DEPTH) : cap_q[CW-1:0];
  assign cnt_sel   = item_q.which_stack ? high_q : low_q;
  assign idx_w     = CW'(idx_q);
  assign empty     = (cnt_sel == '0);
  assign ovf       = ({1'b0, low_q} + {1'b0, high_q}) >= {1'b0, cap_w};
  assign disp_last = ((idx_w + ONE) == cnt_sel);

  always_comb begin
    we     = 1'b0;
    re     = 1'b0;
    addr_w = '0;
    low_d  = low_q;
    high_d = high_q;
    idx_d  = idx_q;
    vld_d  = 1'b0;
    st_d   = ST_OK;
    last_d = 1'b1;
    fmem_d = 1'b0;
    if (cmd_i.exec) begin
      idx_d = '0;
      case (item_q.action)
        ACT_PUSH: begin
          vld_d = 1'b1;
          if (ovf) begin
            st_d = ST_OVF;
          end else begin
            we = 1'b1;
            if (item_q.which_stack) begin
              addr_w = cap_w - ONE - high_q;
              high_d = high_q + ONE;
            end else begin
              addr_w = low_q;
              low_d  = low_q + ONE;
            end
          end
        end
        ACT_POP: begin
          vld_d = 1'b1;
          if (empty) begin
            st_d = ST_EMPTY;
          end else begin
            re     = 1'b1;
            fmem_d = 1'b1;
            if (item_q.which_stack) begin
              addr_w = cap_w - high_q;
              high_d = high_q - ONE;
            end else begin
              addr_w = low_q - ONE;
              low_d  = low_q - ONE;
            end
          end
        end
        ACT_DISP: begin
          if (empty) begin
            vld_d = 1'b1;
            st_d  = ST_EMPTY;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.disp) begin
      re     = 1'b1;
      vld_d  = 1'b1;
      fmem_d = 1'b1;
      last_d = disp_last;
      idx_d  = idx_q + AW'(1);
      addr_w = item_q.which_stack ? (cap_w - ONE - idx_w) : idx_w;
    end
    if (cap_we_i) begin
      low_d  = '0;
      high_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr_w[AW-1:0]] <= item_q.value;
    if (re) rdata_q <= mem[addr_w[AW-1:0]];
    if (cmd_i.load) item_q <= item_i;
    idx_q  <= idx_d;
    st_q   <= st_d;
    last_q <= last_d;
    fmem_q <= fmem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= CAP_RESET;
      low_q  <= '0;
      high_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (cap_we_i) cap_q <= cap_wdata_i;
      low_q  <= low_d;
      high_q <= high_d;
      vld_q  <= vld_d;
    end
  end

  assign cap_o            = cap_q;
  assign stat_o.action    = item_q.action;
  assign stat_o.empty     = empty;
  assign stat_o.disp_last = disp_last;

  assign res_valid_o  = vld_q;
  assign res_o.data   = fmem_q ? rdata_q : '0;
  assign res_o.status = st_q;
  assign res_o.last   = last_q;

endmodule

`default_nettype wire

[hw/rtl/two_stacks_one_array.sv]
// two stacks in one shared memory: register port, controller and datapath
// push, pop: busy while in the execute state, result beat registered from that state
// display of n entries: busy through the execute state and the display sweep, one beat per cycle of the sweep
// display of an empty stack, push and pop: one result each; unused action: no result
// results are never stalled; a new request is accepted only in idle, once the execute state or display sweep is over
// reset: both stacks empty, capacity 64, memory contents undefined and never cleared
`default_nettype none

module two_stacks_one_array #(
  parameter int DEPTH = 64
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  tso_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output tso_pkg::out_item_t res_o,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [2:0]         paddr,
  input  wire  [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tso_pkg::*;

  ctl_cmd_t   cmd;
  dp_stat_t   stat;
  logic       cap_we;
  logic       cap_sel;
  logic [6:0] cap;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[2] == 1'b0);
  assign cap_we  = psel && penable && pwrite && pready && cap_sel;
  assign prdata  = cap_sel ? {25'd0, cap} : 32'd0;

  tso_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  tso_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cap_we_i    (cap_we),
    .cap_wdata_i (pwdata[6:0]),
    .cap_o       (cap),
    .stat_o      (stat),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
